// File: src/integer_to_ascii_digits_core_macros.svh
// assertion macros for the integer to ascii digits core
// used by integer_to_ascii_digits_core, no other dependencies
`ifndef INTEGER_TO_ASCII_DIGITS_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_DIGITS_CORE_MACROS_SVH

// same-cycle implication, checked on i_clk, off during reset
`define I2A_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("i2a check failed");

// next-cycle implication, checked on i_clk, off during reset
`define I2A_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("i2a check failed");

`endif

// File: src/i2a_pkg.sv
// shared types, constants and glyph function for the integer to ascii digits core
// no dependencies
package i2a_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_DIGITS = 10;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int LEFT_W     = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] MODE_UDEC = 2'd0;
    localparam logic [1:0] MODE_SDEC = 2'd1;
    localparam logic [1:0] MODE_HEX  = 2'd2;

    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_ALPHA = 7'h37;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic conv;
        logic dec;
        logic emit;
    } t_cell_ctl;

    function automatic logic [6:0] glyph(input logic [3:0] d);
        logic [6:0] ch;
        if (d < 4'd10) begin
            ch = CH_ZERO + {3'd0, d};
        end else begin
            ch = CH_ALPHA + {3'd0, d};
        end
        return ch;
    endfunction

endpackage

// File: src/integer_to_ascii_digits_core.sv
// top level of the integer to ascii digits core: control, value shifter, cell row
// depends on i2a_pkg, i2a_cell and integer_to_ascii_digits_core_macros.svh
//
// channel | direction | handshake               | payload
// input   | in        | i_in_valid / o_in_stall | i_value[31:0], i_mode[1:0]
// output  | out       | o_out_valid / i_out_stall | o_character[6:0], o_last
//
// one number passes an accept step, a shift phase through the digit cells and a digit
// readout (leading zeros drop out silently), plus a sign step for a minus sign
// the digit cell row shifts one value bit per cycle; a new number is taken only in idle
// sync active-low reset clears control and the output valid
// a stalled output holds its character and pauses the readout of shown digits
module integer_to_ascii_digits_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [i2a_pkg::VALUE_BITS-1:0] i_value,
    input  logic [1:0]                    i_mode,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [6:0]                    o_character,
    output logic                          o_last
);
    import i2a_pkg::*;

    `include "integer_to_ascii_digits_core_macros.svh"

    t_state                  r_state, n_state;
    logic [VALUE_BITS-1:0]   r_value;
    logic [CNT_W-1:0]        r_cnt;
    logic [LEFT_W-1:0]       r_left;
    logic                    r_neg;
    logic                    r_dec;
    logic                    r_ovf;
    logic                    r_started;
    logic                    r_out_valid;
    logic [6:0]              r_char;
    logic                    r_last;

    t_cell_ctl               ctl;
    logic [MAX_DIGITS-1:0]   carry;
    logic [3:0]              digit [MAX_DIGITS];
    logic [VALUE_BITS-1:0]   mag;
    logic                    neg_in;
    logic                    accept;
    logic                    out_free;
    logic [3:0]              top;
    logic                    show;
    logic                    conv_done;
    logic                    load_sign;
    logic                    step_digit;
    logic                    load_digit;

    assign accept    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign top       = digit[MAX_DIGITS-1];
    assign show      = r_started || r_ovf || (top != 4'd0) || (r_left == LEFT_W'(1));
    assign conv_done = (r_state == ST_CONV) && (r_cnt == CNT_W'(VALUE_BITS - 1));
    assign neg_in    = (i_mode == MODE_SDEC) && i_value[VALUE_BITS-1];
    assign mag       = neg_in ? (~i_value + 1'b1) : i_value;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    n_state = r_neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (step_digit && r_left == LEFT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_in_stall = 1'b1;
        load_sign  = 1'b0;
        step_digit = 1'b0;
        load_digit = 1'b0;
        ctl        = '0;
        ctl.dec    = r_dec;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                ctl.clear  = 1'b1;
            end
            ST_CONV: begin
                ctl.conv = 1'b1;
            end
            ST_SIGN: begin
                load_sign = out_free;
            end
            ST_DIGIT: begin
                step_digit = out_free || !show;
                load_digit = out_free && show;
                ctl.emit   = step_digit;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_sign || load_digit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_started <= 1'b0;
            end else if (load_digit) begin
                r_started <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value <= mag;
            r_neg   <= neg_in;
            r_dec   <= (i_mode != MODE_HEX);
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else if (r_state == ST_CONV) begin
            r_value <= {r_value[VALUE_BITS-2:0], 1'b0};
            r_cnt   <= r_cnt + 1'b1;
            r_ovf   <= r_ovf || carry[MAX_DIGITS-1];
        end
        if (conv_done) begin
            r_left <= LEFT_W'(MAX_DIGITS);
        end else if (step_digit) begin
            r_left <= r_left - 1'b1;
        end
        if (load_sign) begin
            r_char <= CH_MINUS;
            r_last <= 1'b0;
        end else if (load_digit) begin
            r_char <= glyph(top);
            r_last <= (r_left == LEFT_W'(1));
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_DIGITS; k++) begin : g_cell
            if (k == 0) begin : g_first
                i2a_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctl   (ctl),
                    .i_bit   (r_value[VALUE_BITS-1]),
                    .i_digit (4'd0),
                    .o_bit   (carry[k]),
                    .o_digit (digit[k])
                );
            end else begin : g_next
                i2a_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctl   (ctl),
                    .i_bit   (carry[k-1]),
                    .i_digit (digit[k-1]),
                    .o_bit   (carry[k]),
                    .o_digit (digit[k])
                );
            end
        end
    endgenerate

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    `I2A_ASSERT_NEXT(a_accept_starts_conv, accept, r_state == ST_CONV && r_cnt == '0)
    `I2A_ASSERT_NOW(a_sign_only_negative, r_state == ST_SIGN, r_neg)
    `I2A_ASSERT_NEXT(a_final_digit_last, load_digit && r_left == LEFT_W'(1),
        o_out_valid && o_last && r_state == ST_IDLE)
    `I2A_ASSERT_NEXT(a_sign_not_last, load_sign, o_out_valid && !o_last && o_character == CH_MINUS)

endmodule

// File: src/i2a_cell.sv
// one digit cell: shift-add-3 bcd step or plain nibble shift, then digit hand-off
// depends on i2a_pkg
module i2a_cell (
    input  logic               i_clk,
    input  i2a_pkg::t_cell_ctl i_ctl,
    input  logic               i_bit,
    input  logic [3:0]         i_digit,
    output logic               o_bit,
    output logic [3:0]         o_digit
);
    import i2a_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] adj;

    always_comb begin
        if (i_ctl.dec && r_digit >= 4'd5) begin
            adj = r_digit + 4'd3;
        end else begin
            adj = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= 4'd0;
        end else if (i_ctl.conv) begin
            r_digit <= {adj[2:0], i_bit};
        end else if (i_ctl.emit) begin
            r_digit <= i_digit;
        end
    end

    assign o_bit   = adj[3];
    assign o_digit = r_digit;

endmodule
